[design/dtps_pkg.sv]
`default_nettype none

package dtps_pkg;

   localparam int MAX_WIDTH_DEF  = 256;
   localparam int MAX_HEIGHT_DEF = 256;

   localparam int CFG_W       = 9;
   localparam int REQ_TDATA_W = 128;
   localparam int RSP_TDATA_W = 120;

   // Operation codes carried in req_tuser
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Configuration register indexes
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] CFG_RESET   = 9'd256;
   localparam logic [30:0]      DEPTH_FAR   = 31'h7FFF_FFFF;
   localparam logic [14:0]      CLEAR_GREEN = 15'd3000;
   localparam logic [14:0]      CLEAR_BLUE  = 15'd1000;
   localparam logic [11:0]      COLOR_CLAMP = 12'd4095;
   localparam int               BYTE_SHIFT  = 4;

   typedef struct packed {
      logic [14:0] alpha;
      logic [30:0] depth;
      logic [14:0] red;
      logic [14:0] green;
      logic [14:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] x;
      logic [15:0] y;
      logic [14:0] red;
      logic [14:0] green;
      logic [14:0] blue;
      logic [14:0] alpha;
      logic [30:0] depth;
   } item_type;

   typedef struct packed {
      logic        status;
      logic        written;
      pixel_type   pixel;
      logic [7:0]  red_byte;
      logic [7:0]  green_byte;
      logic [7:0]  blue_byte;
   } result_type;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic eval;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic req_clear;
      logic clear_last;
   } stat_type;

   function automatic logic [7:0] to_byte(logic [14:0] c);
      logic [11:0] v;
      logic [11:0] s;
      v = (c > {3'b000, COLOR_CLAMP}) ? COLOR_CLAMP : c[11:0];
      s = v >> BYTE_SHIFT;
      return s[7:0];
   endfunction

endpackage

`default_nettype wire

[design/dtps_ctrl.sv]
`default_nettype none

module dtps_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire dtps_pkg::stat_type stat,
   output dtps_pkg::cmd_type      cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_CLEAR = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = stat.req_clear ? S_CLEAR : S_READ;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_last) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold the result until the output register frees up
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken beat");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("ready raised outside idle");

   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_READ || state_ff == S_CLEAR))
      else $error("accepted beat not followed by read or clear");

   a_clear_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR && stat.clear_last) |=> (state_ff == S_EVAL))
      else $error("clear sweep did not end in evaluate");

endmodule

`default_nettype wire

[design/dtps_datapath.sv]
`default_nettype none

module dtps_datapath #(
   parameter int MAX_WIDTH  = dtps_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = dtps_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire dtps_pkg::item_type          req_item,
   input  wire logic                        csr_we,
   input  wire logic                        csr_index,
   input  wire logic [dtps_pkg::CFG_W-1:0]  csr_wdata,
   input  wire dtps_pkg::cmd_type           cmd,
   output dtps_pkg::stat_type               stat,
   output dtps_pkg::result_type             rsp_result
);

   localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

   logic [dtps_pkg::CFG_W-1:0] width_ff, width_in;
   logic [dtps_pkg::CFG_W-1:0] height_ff, height_in;

   dtps_pkg::item_type   item_ff;
   logic                 inside_ff;
   logic [ADDR_W-1:0]    addr_ff;
   logic [ADDR_W-1:0]    clr_idx_ff, clr_idx_in;
   dtps_pkg::pixel_type  rd_ff;
   dtps_pkg::result_type res_ff, res_in;
   dtps_pkg::result_type out_ff;

   dtps_pkg::pixel_type  mem [STORE_SIZE];

   logic [15:0]          w_lim;
   logic [15:0]          h_lim;
   logic                 inside_in;
   logic [31:0]          lin_addr;
   logic [ADDR_W-1:0]    addr_in;

   logic                 pass;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   dtps_pkg::pixel_type  mem_wdata;
   dtps_pkg::pixel_type  clear_pix;

   // Configuration registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            dtps_pkg::CSR_WIDTH:  width_in  = csr_wdata;
            dtps_pkg::CSR_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Bounds check and linear address of the incoming beat
   always_comb begin
      w_lim = (16'(width_ff) > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH) : 16'(width_ff);
      h_lim = (16'(height_ff) > 16'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT) : 16'(height_ff);
      inside_in = !req_item.x[15] && !req_item.y[15]
                  && ({1'b0, req_item.x[14:0]} < w_lim)
                  && ({1'b0, req_item.y[14:0]} < h_lim);
      lin_addr = 32'(req_item.y[14:0]) * 32'(MAX_WIDTH) + 32'(req_item.x[14:0]);
      addr_in  = lin_addr[ADDR_W-1:0];
   end

   assign stat.req_clear  = (req_item.op == dtps_pkg::OP_CLEAR);
   assign stat.clear_last = (clr_idx_ff == ADDR_W'(STORE_SIZE - 1));

   assign clr_idx_in = stat.clear_last ? '0 : clr_idx_ff + 1'b1;

   always_comb begin
      clear_pix.alpha = '0;
      clear_pix.depth = dtps_pkg::DEPTH_FAR;
      clear_pix.red   = '0;
      clear_pix.green = dtps_pkg::CLEAR_GREEN;
      clear_pix.blue  = dtps_pkg::CLEAR_BLUE;
   end

   // Depth test, memory write and result forming
   always_comb begin
      pass = (item_ff.op == dtps_pkg::OP_WRITE) && inside_ff
             && (item_ff.depth != '0) && (item_ff.depth < rd_ff.depth);

      mem_wdata       = rd_ff;
      mem_wdata.alpha = item_ff.alpha;
      if (pass) begin
         mem_wdata.depth = item_ff.depth;
         mem_wdata.red   = item_ff.red;
         mem_wdata.green = item_ff.green;
         mem_wdata.blue  = item_ff.blue;
      end
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_waddr = clr_idx_ff;
         mem_wdata = clear_pix;
      end else if (cmd.eval && item_ff.op == dtps_pkg::OP_WRITE && inside_ff) begin
         mem_we = 1'b1;
      end

      res_in         = '0;
      res_in.written = pass;
      res_in.status  = !inside_ff && (item_ff.op == dtps_pkg::OP_WRITE
                                      || item_ff.op == dtps_pkg::OP_READ);
      if (item_ff.op == dtps_pkg::OP_READ && inside_ff) begin
         res_in.pixel      = rd_ff;
         res_in.red_byte   = dtps_pkg::to_byte(rd_ff.red);
         res_in.green_byte = dtps_pkg::to_byte(rd_ff.green);
         res_in.blue_byte  = dtps_pkg::to_byte(rd_ff.blue);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff   <= req_item;
         inside_ff <= inside_in;
         addr_ff   <= addr_in;
      end
      if (cmd.eval) begin
         res_ff <= res_in;
      end
      if (cmd.load_out) begin
         out_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= dtps_pkg::CFG_RESET;
         height_ff  <= dtps_pkg::CFG_RESET;
         clr_idx_ff <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         if (cmd.clear_step) begin
            clr_idx_ff <= clr_idx_in;
         end
      end
   end

   assign rsp_result = out_ff;

endmodule

`default_nettype wire

[design/depth_tested_pixel_store_unit.sv]
// Depth-buffered pixel store.
// Input beats arrive on req_ (op in req_tuser: write, read or clear); each
// beat produces exactly one result beat on rsp_, status and written flags in
// rsp_tuser and the read pixel with its 8-bit colour bytes in rsp_tdata.
// Display width and height are set through the csr_ write port (index 0
// width, index 1 height); the user must write them only while no beat is
// in flight, which the block itself does not enforce. Both reset to 256 and
// saturate at MAX_WIDTH and MAX_HEIGHT.
// A write or read goes through accept, memory read, depth test and
// write-back, then output load into the result register. The next beat is
// taken in the cycle after the load. A write inside the display writes its
// pixel once and a read writes nothing; items are handled one at a time.
// A clear sweeps the whole store one pixel a cycle.
// Pixel memory holds garbage after reset; issue a clear before the first
// read or write. Reset returns the controller to idle and empties the
// output register.
// A stalled receiver does not block acceptance of the next beat: the result
// waits in the output register while the next beat is taken, and that
// beat's result, and any later beat, waits until the register is free.
`default_nettype none

module depth_tested_pixel_store_unit #(
   parameter int MAX_WIDTH  = dtps_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = dtps_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // x[15:0], y[31:16], red[46:32], green[61:47], blue[76:62],
   // alpha[91:77], depth[122:92], zero fill above
   input  wire logic [dtps_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // op[1:0]
   input  wire logic [1:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // pixel_alpha[14:0], pixel_depth[45:15], pixel_red[60:46],
   // pixel_green[75:61], pixel_blue[90:76], red_byte[98:91],
   // green_byte[106:99], blue_byte[114:107], zero fill above
   output logic [dtps_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   // status[0], written[1]
   output logic [1:0]                             rsp_tuser,
   input  wire logic                              csr_we,
   input  wire logic                              csr_index,
   input  wire logic [dtps_pkg::CFG_W-1:0]        csr_wdata
);

   dtps_pkg::item_type   req_item;
   dtps_pkg::result_type rsp_result;
   dtps_pkg::cmd_type    cmd;
   dtps_pkg::stat_type   stat;

   always_comb begin
      req_item.op    = req_tuser;
      req_item.x     = req_tdata[15:0];
      req_item.y     = req_tdata[31:16];
      req_item.red   = req_tdata[46:32];
      req_item.green = req_tdata[61:47];
      req_item.blue  = req_tdata[76:62];
      req_item.alpha = req_tdata[91:77];
      req_item.depth = req_tdata[122:92];
   end

   always_comb begin
      rsp_tdata          = '0;
      rsp_tdata[14:0]    = rsp_result.pixel.alpha;
      rsp_tdata[45:15]   = rsp_result.pixel.depth;
      rsp_tdata[60:46]   = rsp_result.pixel.red;
      rsp_tdata[75:61]   = rsp_result.pixel.green;
      rsp_tdata[90:76]   = rsp_result.pixel.blue;
      rsp_tdata[98:91]   = rsp_result.red_byte;
      rsp_tdata[106:99]  = rsp_result.green_byte;
      rsp_tdata[114:107] = rsp_result.blue_byte;
      rsp_tuser          = {rsp_result.written, rsp_result.status};
   end

   dtps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   dtps_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_result (rsp_result)
   );

endmodule

`default_nettype wire

[tb/sv/pixel_store_checker.sv]
module pixel_store_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   // x[15:0], y[31:16], red[46:32], green[61:47], blue[76:62],
   // alpha[91:77], depth[122:92], zero fill above
   input  wire logic [dtps_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // op[1:0]
   input  wire logic [1:0]                        req_tuser,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   // pixel_alpha[14:0], pixel_depth[45:15], pixel_red[60:46],
   // pixel_green[75:61], pixel_blue[90:76], red_byte[98:91],
   // green_byte[106:99], blue_byte[114:107], zero fill above
   input  wire logic [dtps_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // status[0], written[1]
   input  wire logic [1:0]                        rsp_tuser,
   input  wire logic                              csr_we,
   input  wire logic                              csr_index,
   input  wire logic [dtps_pkg::CFG_W-1:0]        csr_wdata,
   output int unsigned                            pending_results,
   output int unsigned                            mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import dtps_pkg::*;

   localparam int STORE_W      = MAX_WIDTH_DEF;
   localparam int STORE_H      = MAX_HEIGHT_DEF;
   localparam int STORE_PIXELS = STORE_W * STORE_H;

   localparam pixel_type CLEARED_PIXEL = '{
      alpha: '0, depth: DEPTH_FAR, red: '0, green: CLEAR_GREEN, blue: CLEAR_BLUE
   };

   pixel_type        pixel_mem [STORE_PIXELS];
   logic [CFG_W-1:0] width_reg = CFG_RESET;
   logic [CFG_W-1:0] height_reg = CFG_RESET;
   result_type       expected_q [$];
   int unsigned      errors = 0;

   assign mismatch_count = errors;

   function automatic logic [7:0] intensity_byte(logic [14:0] c);
      // clamp to the 12-bit range, keep the top eight bits
      return (c > 15'(COLOR_CLAMP)) ? 8'hFF : c[11:4];
   endfunction

   task automatic render_fragment(input item_type frag, output result_type res);
      int        col;
      int        row;
      int        w_eff;
      int        h_eff;
      int        addr;
      bit        in_view;
      pixel_type p;
      res     = '0;
      col     = $signed(frag.x);
      row     = $signed(frag.y);
      w_eff   = (width_reg > STORE_W) ? STORE_W : int'(width_reg);
      h_eff   = (height_reg > STORE_H) ? STORE_H : int'(height_reg);
      in_view = col >= 0 && row >= 0 && col < w_eff && row < h_eff;
      addr    = in_view ? row * STORE_W + col : 0;
      case (frag.op)
         OP_WRITE: begin
            if (!in_view) begin
               res.status = 1'b1;
            end else begin
               pixel_mem[addr].alpha = frag.alpha;
               // nearer and nonzero wins; alpha lands regardless
               if (frag.depth != '0 && frag.depth < pixel_mem[addr].depth) begin
                  pixel_mem[addr].depth = frag.depth;
                  pixel_mem[addr].red   = frag.red;
                  pixel_mem[addr].green = frag.green;
                  pixel_mem[addr].blue  = frag.blue;
                  res.written           = 1'b1;
               end
            end
         end
         OP_READ: begin
            if (!in_view) begin
               res.status = 1'b1;
            end else begin
               p              = pixel_mem[addr];
               res.pixel      = p;
               res.red_byte   = intensity_byte(p.red);
               res.green_byte = intensity_byte(p.green);
               res.blue_byte  = intensity_byte(p.blue);
            end
         end
         OP_CLEAR: begin
            foreach (pixel_mem[i]) pixel_mem[i] = CLEARED_PIXEL;
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      item_type   frag;
      result_type want;
      result_type got;
      if (reset) begin
         width_reg  = CFG_RESET;
         height_reg = CFG_RESET;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_WIDTH) width_reg = csr_wdata;
            else                        height_reg = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            frag.op    = req_tuser;
            frag.x     = req_tdata[15:0];
            frag.y     = req_tdata[31:16];
            frag.red   = req_tdata[46:32];
            frag.green = req_tdata[61:47];
            frag.blue  = req_tdata[76:62];
            frag.alpha = req_tdata[91:77];
            frag.depth = req_tdata[122:92];
            render_fragment(frag, want);
            expected_q.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status      = rsp_tuser[0];
            got.written     = rsp_tuser[1];
            got.pixel.alpha = rsp_tdata[14:0];
            got.pixel.depth = rsp_tdata[45:15];
            got.pixel.red   = rsp_tdata[60:46];
            got.pixel.green = rsp_tdata[75:61];
            got.pixel.blue  = rsp_tdata[90:76];
            got.red_byte    = rsp_tdata[98:91];
            got.green_byte  = rsp_tdata[106:99];
            got.blue_byte   = rsp_tdata[114:107];
            if (expected_q.size() == 0) begin
               $error("result beat with no pending request: tuser %0h tdata %0h",
                      rsp_tuser, rsp_tdata);
               errors++;
            end else begin
               want = expected_q.pop_front();
               check_field("status", want.status, got.status);
               check_field("written", want.written, got.written);
               check_field("pixel_alpha", want.pixel.alpha, got.pixel.alpha);
               check_field("pixel_depth", want.pixel.depth, got.pixel.depth);
               check_field("pixel_red", want.pixel.red, got.pixel.red);
               check_field("pixel_green", want.pixel.green, got.pixel.green);
               check_field("pixel_blue", want.pixel.blue, got.pixel.blue);
               check_field("red_byte", want.red_byte, got.red_byte);
               check_field("green_byte", want.green_byte, got.green_byte);
               check_field("blue_byte", want.blue_byte, got.blue_byte);
               check_field("tdata_fill", '0, rsp_tdata[RSP_TDATA_W-1:115]);
            end
         end
      end
      pending_results <= expected_q.size();
   end

endmodule

[tb/sv/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dtps_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         PHASES       = 7;
   localparam int         PHASE_ITEMS  = 190;
   localparam int         DRAIN_CYCLES = 8;
   // a clear sweeps the whole store with no beat moving; allow several of those
   localparam int         IDLE_LIMIT   = 300000;

   typedef enum {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_pattern_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic [1:0]              req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [1:0]              rsp_tuser;
   logic                    csr_we = 1'b0;
   logic                    csr_index = CSR_WIDTH;
   logic [CFG_W-1:0]        csr_wdata = '0;
   int unsigned             pending_results;
   int unsigned             mismatch_count;

   int          burst_left = 0;
   int          eff_w = MAX_WIDTH_DEF;
   int          eff_h = MAX_HEIGHT_DEF;
   int          hot_x = 0;
   int          hot_y = 0;
   logic [30:0] last_depth = 31'd100;
   int          geo_w [PHASES] = '{1, 511, 0, 13, 256, 1, 256};
   int          geo_h [PHASES] = '{1, 256, 100, 7, 511, 1, 256};

   rx_pattern_type stall_mode = RX_ALWAYS;
   int unsigned    mode_cycles = 0;
   logic [2:0]     tick = '0;
   int unsigned    quiet_cycles = 0;

   always #1 clock = ~clock;

   depth_tested_pixel_store_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   pixel_store_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending_results (pending_results),
      .mismatch_count  (mismatch_count)
   );

   // receiver: switch at random between four stall patterns
   always @(posedge clock) begin
      tick <= tick + 3'd1;
      if (mode_cycles == 0) begin
         stall_mode  <= rx_pattern_type'($urandom_range(0, 3));
         mode_cycles <= $urandom_range(16, 160);
      end else begin
         mode_cycles <= mode_cycles - 1;
      end
      case (stall_mode)
         RX_ALWAYS:   rsp_tready <= 1'b1;
         RX_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         RX_PERIODIC: rsp_tready <= (tick[2:1] != 2'b00);
         default:     rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic item_type make_item(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                                          logic [14:0] r, logic [14:0] g, logic [14:0] b,
                                          logic [14:0] a, logic [30:0] d);
      item_type it;
      it.op    = op;
      it.x     = x;
      it.y     = y;
      it.red   = r;
      it.green = g;
      it.blue  = b;
      it.alpha = a;
      it.depth = d;
      return it;
   endfunction

   function automatic logic [15:0] pick_coord(int limit, int hot);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return 16'(hot + int'($urandom_range(0, 3)));
         5, 6:          return (limit > 0) ? 16'($urandom_range(0, limit - 1))
                                           : 16'($urandom);
         7: begin
            case ($urandom_range(0, 5))
               0:       return 16'hFFFF;
               1:       return 16'h0000;
               2:       return 16'(limit - 1);
               3:       return 16'(limit);
               4:       return 16'h8000;
               default: return 16'h7FFF;
            endcase
         end
         default:       return 16'($urandom);
      endcase
   endfunction

   function automatic logic [14:0] random_intensity();
      case ($urandom_range(0, 3))
         0:       return 15'($urandom);
         1:       return 15'(int'(COLOR_CLAMP) - 5 + int'($urandom_range(0, 11)));
         2:       return $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
         default: return 15'($urandom_range(0, int'(COLOR_CLAMP)));
      endcase
   endfunction

   function automatic item_type random_fragment();
      item_type    it;
      int unsigned pick;
      pick     = $urandom_range(0, 99);
      it.op    = (pick < 48) ? OP_WRITE : (pick < 96) ? OP_READ : OP_UNUSED;
      it.x     = pick_coord(eff_w, hot_x);
      it.y     = pick_coord(eff_h, hot_y);
      it.red   = random_intensity();
      it.green = random_intensity();
      it.blue  = random_intensity();
      it.alpha = 15'($urandom);
      case ($urandom_range(0, 9))
         0:          it.depth = '0;
         1:          it.depth = DEPTH_FAR;
         2:          it.depth = DEPTH_FAR - 31'd1;
         3, 4:       it.depth = 31'($urandom);
         5, 6, 7:    it.depth = 31'($urandom_range(1, 200));
         8:          it.depth = last_depth;
         default:    it.depth = last_depth - 31'd1;
      endcase
      if (it.op == OP_WRITE) last_depth = it.depth;
      return it;
   endfunction

   task automatic send_item(input item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {5'b0, it.depth, it.alpha, it.blue, it.green, it.red, it.y, it.x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // drop valid and hold until every result beat has drained
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(input int w, input int h);
      csr_we    <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= CFG_W'(w);
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= CFG_W'(h);
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      eff_w = (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w;
      eff_h = (h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h;
   endtask

   initial begin
      item_type frag;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // store must be cleared before any pixel access
      send_item(make_item(OP_CLEAR, 16'h0, 16'h0, '0, '0, '0, '0, '0));
      send_item(make_item(OP_READ, 16'd0, 16'd0, '0, '0, '0, '0, '0));
      send_item(make_item(OP_WRITE, 16'd0, 16'd0, 15'h7FFF, 15'h7FFF, 15'h7FFF,
                          15'h7FFF, 31'd100));
      send_item(make_item(OP_READ, 16'd0, 16'd0, '0, '0, '0, '0, '0));
      // equal depth and zero depth both lose, alpha still lands
      send_item(make_item(OP_WRITE, 16'd0, 16'd0, 15'd1, 15'd2, 15'd3, 15'd5, 31'd100));
      send_item(make_item(OP_WRITE, 16'd0, 16'd0, 15'd9, 15'd9, 15'd9, 15'd6, 31'd0));
      send_item(make_item(OP_WRITE, 16'd0, 16'd0, 15'd4095, 15'd4096, 15'd4094, 15'd0,
                          31'd99));
      send_item(make_item(OP_READ, 16'd0, 16'd0, '0, '0, '0, '0, '0));
      send_item(make_item(OP_WRITE, 16'd255, 16'd255, 15'd7, 15'd7, 15'd7, 15'd7,
                          DEPTH_FAR));
      send_item(make_item(OP_WRITE, 16'd255, 16'd255, '0, '0, '0, 15'd1,
                          DEPTH_FAR - 31'd1));
      send_item(make_item(OP_READ, 16'd255, 16'd255, '0, '0, '0, '0, '0));
      send_item(make_item(OP_WRITE, 16'd256, 16'd0, 15'd1, 15'd1, 15'd1, 15'd1, 31'd1));
      send_item(make_item(OP_READ, 16'hFFFF, 16'd0, '0, '0, '0, '0, '0));
      send_item(make_item(OP_READ, 16'd0, 16'h8000, '0, '0, '0, '0, '0));
      send_item(make_item(OP_WRITE, 16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF,
                          15'h7FFF, 31'd1));
      send_item(make_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF,
                          15'h7FFF, DEPTH_FAR));
      send_item(make_item(OP_READ, 16'd255, 16'd0, '0, '0, '0, '0, '0));
      send_item(make_item(OP_READ, 16'd0, 16'd255, '0, '0, '0, '0, '0));
      send_item(make_item(OP_CLEAR, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 15'h7FFF,
                          15'h7FFF, DEPTH_FAR));
      send_item(make_item(OP_READ, 16'd0, 16'd0, '0, '0, '0, '0, '0));
      send_item(make_item(OP_READ, 16'd255, 16'd255, '0, '0, '0, '0, '0));

      geo_w[5] = $urandom_range(1, MAX_WIDTH_DEF);
      geo_h[5] = $urandom_range(1, MAX_HEIGHT_DEF);
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         set_geometry(geo_w[phase], geo_h[phase]);
         if (phase % 2 == 0) begin
            frag    = random_fragment();
            frag.op = OP_CLEAR;
            send_item(frag);
         end
         // concentrate traffic on a small window so pixels get rewritten
         hot_x = (eff_w > 0) ? $urandom_range(0, eff_w - 1) : 0;
         hot_y = (eff_h > 0) ? $urandom_range(0, eff_h - 1) : 0;
         repeat (PHASE_ITEMS) send_item(random_fragment());
      end
      wait_idle();

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
